>>> rtl/core/assert_macros.svh
// assertion macros shared by the missing-jet redistribution rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define MJDR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property check failed");
// expression must never be true outside reset
`define MJDR_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define MJDR_ASSERT(lbl, clk, rst, prop)
`define MJDR_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> rtl/core/mjdr_pkg.sv
// types and constants of the missing-jet drop redistribution block
// no dependencies
package mjdr_pkg;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DROP_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TWO_BIT_PIXELS = 1'd1;

   localparam logic [1:0] MAX_DROP_SIZE_RST  = 2'd3;
   localparam logic       TWO_BIT_PIXELS_RST = 1'b1;

   localparam logic [1:0] DEPTH_TWO_BIT = 2'h3;
   localparam logic [1:0] DEPTH_ONE_BIT = 2'h1;

   localparam int unsigned OWED_W   = 3;
   localparam logic [2:0]  OWED_MAX = 3'd6;

   typedef struct packed {
      logic       column_start;
      logic [1:0] left_pixel;
      logic [1:0] center_pixel;
      logic [1:0] right_pixel;
   } req_type;

   typedef struct packed {
      logic [1:0] left_out;
      logic [1:0] right_out;
      logic [1:0] center_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0] max_drop_size;
      logic       two_bit_pixels;
   } cfg_type;

   // classified line, pixels already masked to the pixel depth
   typedef struct packed {
      logic       column_start;
      logic [1:0] org_left;
      logic [1:0] dead_size;
      logic [1:0] org_right;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [1:0] pixel_depth(input logic two_bit);
      return two_bit ? DEPTH_TWO_BIT : DEPTH_ONE_BIT;
   endfunction

endpackage

>>> rtl/core/mjdr_front.sv
// front end: takes line items and masks them to the pixel depth
// depends on mjdr_pkg
module mjdr_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mjdr_pkg::req_type    req_data,
   input  mjdr_pkg::cfg_type    cfg,
   input  mjdr_pkg::q_stat_type q_stat,
   output logic                 q_push,
   output mjdr_pkg::job_type    q_job
);
   import mjdr_pkg::*;

   logic [1:0] depth;

   assign depth     = pixel_depth(cfg.two_bit_pixels);
   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   // one-bit pixel stores deliver only the low bit
   assign q_job.column_start = req_data.column_start;
   assign q_job.org_left     = req_data.left_pixel & depth;
   assign q_job.dead_size    = req_data.center_pixel & depth;
   assign q_job.org_right    = req_data.right_pixel & depth;

endmodule

>>> rtl/core/mjdr_fifo.sv
// short queue of classified lines between front and back
// depends on mjdr_pkg and assert_macros.svh
`include "assert_macros.svh"
module mjdr_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mjdr_pkg::job_type    wr_job,
   input  logic                 pop,
   output mjdr_pkg::job_type    rd_job,
   output mjdr_pkg::q_stat_type status
);
   import mjdr_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign rd_job       = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= wr_job;
      end
   end

   `MJDR_ASSERT(a_count_range, clock, reset, count_ff <= FULL_CNT)
   `MJDR_ASSERT_NEVER(a_push_full, clock, reset, push && status.full)
   `MJDR_ASSERT_NEVER(a_pop_empty, clock, reset, pop && status.empty)

endmodule

>>> rtl/core/mjdr_back.sv
// back end: owed-droplet bookkeeping and the alternating hand-out sequencer
// depends on mjdr_pkg and assert_macros.svh
`include "assert_macros.svh"
module mjdr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mjdr_pkg::cfg_type    cfg,
   input  mjdr_pkg::q_stat_type q_stat,
   input  mjdr_pkg::job_type    q_job,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mjdr_pkg::rsp_type    rsp_data
);
   import mjdr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

   back_state_type    st_ff, st_in;
   logic [OWED_W-1:0] owed_ff, owed_in;
   logic [2:0]        budget_ff, budget_in;
   logic              side_ff, side_in;
   logic [1:0]        comp_ff [2];
   logic [1:0]        comp_in [2];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [2:0]        cap;
   logic [1:0]        depth;
   logic [OWED_W-1:0] owed_base;
   logic [3:0]        owed_sum;
   logic [2:0]        used;
   logic              out_free;

   assign cap      = {cfg.max_drop_size, 1'b0};
   assign depth    = pixel_depth(cfg.two_bit_pixels);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (st_ff == ST_IDLE) && !q_stat.empty;

   assign owed_base = q_job.column_start ? '0 : owed_ff;
   assign owed_sum  = {1'b0, owed_base} + {2'b00, q_job.dead_size};
   assign used      = {1'b0, q_job.org_left} + {1'b0, q_job.org_right};

   always_comb begin
      st_in        = st_ff;
      owed_in      = owed_ff;
      budget_in    = budget_ff;
      side_in      = side_ff;
      comp_in[0]   = comp_ff[0];
      comp_in[1]   = comp_ff[1];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               owed_in = owed_base;
               // cap applies only on lines where the dead jet had a dot
               if (q_job.dead_size != '0) begin
                  owed_in = (owed_sum > {1'b0, cap}) ? cap : owed_sum[OWED_W-1:0];
               end
               side_in    = q_job.column_start ? 1'b0 : side_ff;
               budget_in  = (cap > used) ? cap - used : '0;
               comp_in[0] = q_job.org_left;
               comp_in[1] = q_job.org_right;
               st_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            if (owed_ff == '0 || budget_ff == '0) begin
               st_in = ST_DONE;
            end else begin
               if (comp_ff[side_ff] < cfg.max_drop_size) begin
                  comp_in[side_ff] = comp_ff[side_ff] + 1'b1;
                  owed_in          = owed_ff - 1'b1;
                  budget_in        = budget_ff - 1'b1;
               end
               side_in = !side_ff;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.left_out   = (comp_ff[0] > depth) ? depth : comp_ff[0];
               rsp_data_in.right_out  = (comp_ff[1] > depth) ? depth : comp_ff[1];
               rsp_data_in.center_out = '0;
               st_in                  = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         owed_ff      <= '0;
         side_ff      <= 1'b0;
         budget_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         owed_ff      <= owed_in;
         side_ff      <= side_in;
         budget_ff    <= budget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      comp_ff[0]  <= comp_in[0];
      comp_ff[1]  <= comp_in[1];
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MJDR_ASSERT(a_owed_range, clock, reset, owed_ff <= OWED_MAX)
   `MJDR_ASSERT(a_budget_range, clock, reset, budget_ff <= OWED_MAX)
   `MJDR_ASSERT(a_done_loads_out, clock, reset, (st_ff == ST_DONE && out_free) |=> rsp_valid_ff)

endmodule

>>> rtl/core/missing_jet_drop_redistribution_top.sv
// top level of the missing-jet drop redistribution block
// depends on mjdr_pkg, mjdr_front, mjdr_fifo, mjdr_back and assert_macros.svh

// Redistributes the dots of a disabled inkjet nozzle onto its two neighbours,
// one print line per item, working down the nozzle's pixel column. Each item
// carries the left, dead and right dot sizes; the result carries the raised
// neighbour sizes (clamped to the pixel depth) and a zero for the dead jet.
// The front end masks the pixels to the depth and drops them into a queue of
// QUEUE_DEPTH lines, so req_ready stays high while the queue has room even if
// a finished result is still waiting on rsp. The back end holds the owed count
// and the side that gets the next droplet, and steps the side alternation one
// turn per clock. A line passes through the back end in order: loading the line
// and updating the owed count, the turns (at most twice the droplets handed
// out, so up to 12), a check that nothing more is owed or the line budget is
// gone, and the move of the result into the output register, which waits while
// an earlier result is still held on rsp. The back end takes the next line
// from the queue only once the result is in the output register. Configuration
// is plain writes (csr_we, csr_index, csr_wdata): index 0 is max_drop_size,
// index 1 is two_bit_pixels; write only while no line is in flight.
module missing_jet_drop_redistribution_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // line items in
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mjdr_pkg::req_type                   req_data,
   // compensated items out
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mjdr_pkg::rsp_type                   rsp_data,
   // configuration writes
   input  logic                                csr_we,
   input  logic [mjdr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mjdr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mjdr_pkg::*;

   // configuration registers
   cfg_type    cfg_ff, cfg_in;

   // front to queue, queue to back
   q_stat_type q_stat;
   logic       q_push;
   logic       q_pop;
   job_type    q_wr_job;
   job_type    q_rd_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_DROP_SIZE:  cfg_in.max_drop_size  = csr_wdata[1:0];
            CSR_TWO_BIT_PIXELS: cfg_in.two_bit_pixels = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_drop_size  <= MAX_DROP_SIZE_RST;
         cfg_ff.two_bit_pixels <= TWO_BIT_PIXELS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // masks each line to the pixel depth and queues it
   mjdr_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_job     (q_wr_job)
   );

   // lets the front keep accepting while the back works on a line
   mjdr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_job (q_wr_job),
      .pop    (q_pop),
      .rd_job (q_rd_job),
      .status (q_stat)
   );

   // owed count, side alternation and the output register
   mjdr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .q_job     (q_rd_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sv/missing_jet_drop_redistribution_top_test.sv
// self-checking testbench for missing_jet_drop_redistribution_top
// drives print lines and register writes and checks every compensated item
// against a line-by-line predictor; depends on mjdr_pkg and the block's rtl
module missing_jet_drop_redistribution_top_test;
   import mjdr_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;

   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and of the column state
   logic [1:0] drop_size_cfg  = MAX_DROP_SIZE_RST;
   logic       two_bit_cfg    = TWO_BIT_PIXELS_RST;
   logic [2:0] owed_droplets  = '0;
   logic       next_side      = 1'b0;

   rsp_type compensated_q[$];
   int      mismatch_count = 0;

   // random idling on both sides; cleared for the full-rate stretch
   bit gaps_enabled = 1'b1;
   // receiver hold-off request, picked up and counted by the receiver
   int rsp_hold_request = 0;

   missing_jet_drop_redistribution_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one print line through the dead-jet column: clear the dead dot, add it to
   // the owed count (capped), then hand droplets left/right within the budget
   function automatic rsp_type redistribute_line(input req_type line);
      logic [1:0] depth;
      int         cap;
      int         owed;
      int         budget;
      int         dead;
      int         comp [2];
      rsp_type    res;
      depth = two_bit_cfg ? DEPTH_TWO_BIT : DEPTH_ONE_BIT;
      cap   = 2 * drop_size_cfg;
      if (line.column_start) begin
         owed_droplets = '0;
         next_side     = 1'b0;
      end
      // one-bit pixels are seen through their low bit only
      comp[0] = line.left_pixel & depth;
      comp[1] = line.right_pixel & depth;
      dead    = line.center_pixel & depth;
      owed    = owed_droplets;
      if (dead != 0) begin
         owed = owed + dead;
         if (owed > cap) owed = cap;
      end
      if (owed != 0) begin
         // neighbours already above the budget leave nothing to hand out
         budget = cap - comp[0] - comp[1];
         if (budget < 0) budget = 0;
         for (int turn = 0; turn < 32 && owed != 0 && budget != 0; turn++) begin
            // a full side is skipped but still loses its turn
            if (comp[next_side] < drop_size_cfg) begin
               comp[next_side]++;
               owed--;
               budget--;
            end
            next_side = ~next_side;
         end
      end
      owed_droplets  = owed[2:0];
      res.left_out   = (comp[0] > depth) ? depth : comp[0][1:0];
      res.right_out  = (comp[1] > depth) ? depth : comp[1][1:0];
      res.center_out = 2'd0;
      return res;
   endfunction

   // offer one item; valid stays high afterwards so back-to-back items keep it up
   task automatic send_line(input req_type line);
      while (gaps_enabled && $urandom_range(99) < 36) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = line;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      compensated_q.push_back(redistribute_line(line));
      @(negedge clock);
   endtask

   // sender pauses until every expected item is back and the block is quiet
   task automatic wait_for_results;
      req_valid = 1'b0;
      while (compensated_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_MAX_DROP_SIZE:  drop_size_cfg = value[1:0];
         CSR_TWO_BIT_PIXELS: two_bit_cfg   = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [1:0] drop_size, input logic two_bit);
      wait_for_results();
      write_reg(CSR_MAX_DROP_SIZE, drop_size);
      write_reg(CSR_TWO_BIT_PIXELS, {1'b0, two_bit});
   endtask

   function automatic logic [1:0] pick_neighbour;
      // low neighbours half the time so droplets actually get placed
      return ($urandom_range(1) != 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
   endfunction

   // a well-formed column: starts with column_start, rare stray restarts inside
   task automatic send_column(input int lines);
      req_type line;
      for (int i = 0; i < lines; i++) begin
         line.column_start = (i == 0) || ($urandom_range(99) < 3);
         line.left_pixel   = pick_neighbour();
         line.right_pixel  = pick_neighbour();
         line.center_pixel = ($urandom_range(99) < 30) ? 2'd0 : 2'($urandom_range(3, 1));
         send_line(line);
      end
   endtask

   // reset settings: accumulation, cap, full neighbours, mid-column restart
   task automatic test_reset_settings;
      send_line(req_type'{1'b1, 2'd0, 2'd0, 2'd0});
      send_line(req_type'{1'b0, 2'd0, 2'd3, 2'd0});
      // neighbours above the budget: nothing handed, owed count kept
      send_line(req_type'{1'b0, 2'd3, 2'd3, 2'd3});
      send_line(req_type'{1'b0, 2'd3, 2'd3, 2'd3});
      send_line(req_type'{1'b0, 2'd3, 2'd3, 2'd3});
      send_line(req_type'{1'b0, 2'd0, 2'd0, 2'd0});
      send_line(req_type'{1'b0, 2'd3, 2'd0, 2'd0});
      send_line(req_type'{1'b0, 2'd2, 2'd1, 2'd3});
      send_line(req_type'{1'b1, 2'd3, 2'd3, 2'd3});
      send_line(req_type'{1'b0, 2'd1, 2'd2, 2'd2});
      send_line(req_type'{1'b0, 2'd0, 2'd0, 2'd1});
   endtask

   // drop size zero: cap is zero, neighbours pass straight through
   task automatic test_zero_drop_size;
      set_config(2'd0, 1'b1);
      send_line(req_type'{1'b0, 2'd1, 2'd3, 2'd2});
      send_line(req_type'{1'b1, 2'd3, 2'd3, 2'd0});
      send_line(req_type'{1'b0, 2'd0, 2'd2, 2'd3});
   endtask

   // one-bit pixels: only the low bit counts, raised sizes clamp to one
   task automatic test_one_bit_pixels;
      set_config(2'd1, 1'b0);
      send_line(req_type'{1'b1, 2'd2, 2'd2, 2'd2});
      send_line(req_type'{1'b0, 2'd3, 2'd3, 2'd3});
      send_line(req_type'{1'b0, 2'd0, 2'd1, 2'd0});
      set_config(2'd3, 1'b0);
      send_line(req_type'{1'b1, 2'd0, 2'd1, 2'd0});
      send_line(req_type'{1'b0, 2'd1, 2'd3, 2'd2});
      send_line(req_type'{1'b0, 2'd0, 2'd0, 2'd0});
   endtask

   // random columns over several settings, the extremes among them
   task automatic test_random_columns;
      logic [1:0] drop_size;
      logic       two_bit;
      int         sent;
      int         len;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin drop_size = 2'd3; two_bit = 1'b1; end
            1: begin drop_size = 2'd0; two_bit = 1'b0; end
            2: begin drop_size = 2'd1; two_bit = 1'b1; end
            3: begin drop_size = 2'd2; two_bit = 1'b0; end
            4: begin drop_size = 2'($urandom_range(3)); two_bit = 1'($urandom_range(1)); end
            default: begin drop_size = 2'd3; two_bit = 1'b0; end
         endcase
         set_config(drop_size, two_bit);
         sent = 0;
         while (sent < 140) begin
            len = $urandom_range(40, 1);
            send_column(len);
            sent += len;
         end
      end
   endtask

   // long stretch with no idling on either side
   task automatic test_full_rate;
      set_config(2'd3, 1'b1);
      gaps_enabled = 1'b0;
      send_column(150);
      wait_for_results();
      gaps_enabled = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering, so the queue fills
   task automatic test_backpressure;
      set_config(2'd2, 1'b1);
      rsp_hold_request = 300;
      send_column(14);
      wait_for_results();
      rsp_hold_request = 200;
      send_column(16);
      wait_for_results();
   endtask

   // receiver: random stalls, plus hold-offs counted here
   initial begin : drive_rsp_ready
      int hold_count;
      hold_count = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            hold_count       = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_count > 0) begin
            rsp_ready = 1'b0;
            hold_count--;
         end else if (gaps_enabled) begin
            rsp_ready = ($urandom_range(99) >= 36);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic check_field(input string field, input logic [1:0] want,
                              input logic [1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // every accepted result against the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (compensated_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = compensated_q.pop_front();
            check_field("left_out", want.left_out, rsp_data.left_out);
            check_field("right_out", want.right_out, rsp_data.right_out);
            check_field("center_out", want.center_out, rsp_data.center_out);
         end
      end
   end

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_reset_settings();
      test_zero_drop_size();
      test_one_bit_pixels();
      test_random_columns();
      test_full_rate();
      test_backpressure();
      wait_for_results();
      // allow for a late stray item from the back end
      repeat (20) @(negedge clock);
      if (compensated_q.size() != 0) begin
         $display("%0t: %0d items never arrived", $time, compensated_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mjdr_pkg.sv
rtl/core/mjdr_front.sv
rtl/core/mjdr_fifo.sv
rtl/core/mjdr_back.sv
rtl/core/missing_jet_drop_redistribution_top.sv
tb/sv/missing_jet_drop_redistribution_top_test.sv
